@@ sv/bgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgcd_pkg
// Types and constants shared by the button gesture and combo detector.
// ----------------------------------------------------------------------------
package bgcd_pkg;

	localparam int BUTTONS_DEF   = 8;
	localparam int COMBOS_DEF    = 4;
	localparam int MAX_STEPS_DEF = 8;

	localparam logic [15:0] DEBOUNCE_RST  = 16'd20;
	localparam logic [15:0] LONG_RST      = 16'd600;
	localparam logic [15:0] DOUBLE_GAP_RST = 16'd350;

	localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [2:0] REG_LONG       = 3'd1;
	localparam logic [2:0] REG_DOUBLE_GAP = 3'd2;
	localparam logic [2:0] REG_COMBO_CNT  = 3'd3;
	localparam logic [2:0] REG_COMBO_A    = 3'd4;
	localparam logic [2:0] REG_COMBO_B    = 3'd5;
	localparam logic [2:0] REG_COMBO_C    = 3'd6;
	localparam logic [2:0] REG_COMBO_D    = 3'd7;

	localparam logic [1:0] KIND_PRESS  = 2'd0;
	localparam logic [1:0] KIND_COMBO  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] PRESS_SHORT  = 2'd0;
	localparam logic [1:0] PRESS_LONG   = 2'd1;
	localparam logic [1:0] PRESS_DOUBLE = 2'd2;

	typedef struct packed {
		logic [31:0] now_time;
		logic [7:0]  raw_levels;
	} in_word_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [2:0] button_id;
		logic [1:0] press_kind;
		logic       suppressed;
		logic [1:0] combo_id;
		logic [7:0] stable_levels;
		logic [7:0] hold_active;
		logic [3:0] chords_held;
		logic       activity;
		logic       last_item;
	} out_word_t;

endpackage

@@ sv/button_gesture_combo_detector_unit.sv @@
// ----------------------------------------------------------------------------
// button_gesture_combo_detector_unit
// Debounce, long/double/short press, sequence and chord combo detection.
// ----------------------------------------------------------------------------
// One poll word is handled at a time by a sequencer that walks the buttons and
// then the combos, sharing one 32-bit subtract-and-compare unit for every
// elapsed-time and span test. Each button passes the debounce, long-press and
// gap states, also the double-press state when a release is accepted before a
// long press fired, and the sequence states for the combos when a short press
// advances the sequence combos. The chord walk makes two passes over the
// combos, stepping through the members of each chord in use: the first pass
// may fire chords, the second records which chords are held. After the
// accepting step and the walks comes the status word; any state that emits a
// result word waits until the output is free. The block takes no new poll
// until the status word of the current one has gone, and holds off polls
// while a register write is offered.
module button_gesture_combo_detector_unit #(
	parameter int BUTTONS   = bgcd_pkg::BUTTONS_DEF,
	parameter int COMBOS    = bgcd_pkg::COMBOS_DEF,
	parameter int MAX_STEPS = bgcd_pkg::MAX_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bgcd_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bgcd_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [44:0]         cfg_data
);

	localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int CW = (COMBOS > 1) ? $clog2(COMBOS) : 1;
	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam logic [3:0] MAXLEN = 4'(MAX_STEPS);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_DEB    = 12'b000000000010,
		ST_LONG   = 12'b000000000100,
		ST_GAP    = 12'b000000001000,
		ST_SEQW   = 12'b000000010000,
		ST_SEQ    = 12'b000000100000,
		ST_CHK    = 12'b000001000000,
		ST_SPAN   = 12'b000010000000,
		ST_FIRE   = 12'b000100000000,
		ST_STAT   = 12'b001000000000,
		ST_EMIT   = 12'b010000000000,
		ST_DBL    = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [15:0] debounce_q, long_q, gap_q;
	logic [2:0]  ccount_q;
	logic [44:0] cdef_q [COMBOS];

	logic [BUTTONS-1:0] raw_q, stab_q, lfired_q, pend_q, taken_q;
	logic [31:0] rchg_q [BUTTONS];
	logic [31:0] pstart_q [BUTTONS];
	logic [31:0] rel_q [BUTTONS];
	logic [3:0]  prog_q [COMBOS];
	logic [31:0] sstart_q [COMBOS];
	logic [COMBOS-1:0] cdone_q, held_q;

	logic [31:0] now_q;
	logic [7:0]  rawin_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] c_q;
	logic [SW-1:0] k_q;
	logic [31:0] lo_q, hi_q;
	logic        fail_q;
	logic        stat_pass_q;

	logic        out_valid_q;
	bgcd_pkg::out_word_t out_q;

	// Shared unit: elapsed (a - b) >= d, unsigned, 33-bit duration.
	logic [31:0] ua, ub;
	logic [32:0] ud;
	logic [31:0] udiff;
	logic        uge;
	assign udiff = ua - ub;
	assign uge   = {1'b0, udiff} >= ud;

	logic [2:0] used;
	assign used = (ccount_q > 3'(COMBOS)) ? 3'(COMBOS) : ccount_q;

	function automatic logic [3:0] dlen(input logic [44:0] d);
		return (d[4:1] > MAXLEN) ? MAXLEN : d[4:1];
	endfunction

	function automatic logic [2:0] dbtn(input logic [44:0] d, input logic [2:0] k);
		return d[5 + 3*k +: 3];
	endfunction

	function automatic bgcd_pkg::out_word_t press_word(input logic [2:0] btn,
		input logic [1:0] pk, input logic sup);
		bgcd_pkg::out_word_t w;
		w = '0;
		w.item_kind = bgcd_pkg::KIND_PRESS;
		w.button_id = btn;
		w.press_kind = pk;
		w.suppressed = sup;
		return w;
	endfunction

	function automatic bgcd_pkg::out_word_t combo_word(input logic [1:0] cid);
		bgcd_pkg::out_word_t w;
		w = '0;
		w.item_kind = bgcd_pkg::KIND_COMBO;
		w.combo_id = cid;
		return w;
	endfunction

	function automatic bgcd_pkg::out_word_t status_word(input logic [7:0] stab,
		input logic [7:0] hold, input logic [3:0] held, input logic a);
		bgcd_pkg::out_word_t w;
		w = '0;
		w.item_kind = bgcd_pkg::KIND_STATUS;
		w.stable_levels = stab;
		w.hold_active = hold;
		w.chords_held = held;
		w.activity = a;
		w.last_item = 1'b1;
		return w;
	endfunction

	logic [44:0] cd;
	logic [3:0]  clen;
	logic        cuse;
	logic        bit_raw;
	logic [2:0]  mbtn;
	logic        mok;
	logic [BW-1:0] midx;
	logic [31:0] mstart;
	assign cd   = cdef_q[c_q];
	assign clen = dlen(cd);
	assign cuse = (3'(c_q) < used) && (clen != 4'd0);
	assign bit_raw = rawin_q[b_q];
	assign mbtn = dbtn(cd, 3'(k_q));
	assign mok  = ({1'b0, mbtn} < 4'(BUTTONS));
	assign midx = BW'(mbtn);
	assign mstart = pstart_q[midx];

	logic [3:0] prog;
	assign prog = prog_q[c_q];

	// Shared unit operand selection.
	always_comb begin
		ua = now_q;
		ub = 32'd0;
		ud = 33'd0;
		unique case (state_q)
			ST_DEB: begin
				ub = rchg_q[b_q];
				ud = {17'd0, debounce_q};
			end
			ST_DBL: begin
				ub = rel_q[b_q];
				ud = {17'd0, gap_q} + 33'd1;
			end
			ST_LONG: begin
				ub = pstart_q[b_q];
				ud = {17'd0, long_q};
			end
			ST_GAP: begin
				ub = rel_q[b_q];
				ud = {17'd0, gap_q};
			end
			ST_SEQW: begin
				ub = sstart_q[c_q];
				ud = {17'd0, cd[44:29]};
			end
			ST_SPAN: begin
				// Window >= span.
				ua = {16'd0, cd[44:29]};
				ub = 32'd0;
				ud = {1'b0, hi_q - lo_q};
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	logic last_b, last_c;
	assign last_b = (b_q == BW'(BUTTONS - 1));
	assign last_c = (c_q == CW'(COMBOS - 1));

	logic [7:0] stab8, hold8;
	assign stab8 = 8'(stab_q);
	assign hold8 = 8'(stab_q & lfired_q);

	logic act;
	always_comb begin
		act = |raw_q || |stab_q || |pend_q;
		for (int i = 0; i < COMBOS; i++) begin
			if ((3'(i) < used) && ((prog_q[i] != 4'd0) || cdone_q[i])) act = 1'b1;
		end
	end

	// Members of the current chord that exist.
	logic [BUTTONS-1:0] fire_mask;
	always_comb begin
		fire_mask = '0;
		for (int k = 0; k < MAX_STEPS; k++) begin
			if (4'(k) < clen && ({1'b0, dbtn(cd, 3'(k))} < 4'(BUTTONS)))
				fire_mask[BW'(dbtn(cd, 3'(k)))] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin : ctl_p
		logic ov_d;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			debounce_q <= bgcd_pkg::DEBOUNCE_RST;
			long_q <= bgcd_pkg::LONG_RST;
			gap_q <= bgcd_pkg::DOUBLE_GAP_RST;
			ccount_q <= 3'd0;
			raw_q <= '0;
			stab_q <= '0;
			lfired_q <= '0;
			pend_q <= '0;
			taken_q <= '0;
			cdone_q <= '0;
			held_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			now_q <= '0;
			rawin_q <= '0;
			b_q <= '0;
			c_q <= '0;
			k_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			fail_q <= 1'b0;
			stat_pass_q <= 1'b0;
			for (int i = 0; i < BUTTONS; i++) begin
				rchg_q[i] <= '0;
				pstart_q[i] <= '0;
				rel_q[i] <= '0;
			end
			for (int i = 0; i < COMBOS; i++) begin
				cdef_q[i] <= '0;
				prog_q[i] <= '0;
				sstart_q[i] <= '0;
			end
		end else begin
			ov_d = out_valid_q && !out_ready;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						unique case (cfg_index)
							bgcd_pkg::REG_DEBOUNCE:   debounce_q <= cfg_data[15:0];
							bgcd_pkg::REG_LONG:       long_q <= cfg_data[15:0];
							bgcd_pkg::REG_DOUBLE_GAP: gap_q <= cfg_data[15:0];
							bgcd_pkg::REG_COMBO_CNT:  ccount_q <= cfg_data[2:0];
							default: begin
								for (int i = 0; i < COMBOS; i++) begin
									if (cfg_index == bgcd_pkg::REG_COMBO_A + 3'(i))
										cdef_q[i] <= cfg_data;
								end
							end
						endcase
						if ({1'b0, cfg_index} < 4'(bgcd_pkg::REG_COMBO_A) + 4'(COMBOS))
						begin
							taken_q <= '0;
							cdone_q <= '0;
							for (int i = 0; i < COMBOS; i++) begin
								prog_q[i] <= '0;
								sstart_q[i] <= '0;
							end
						end
					end else if (in_valid && in_ready) begin
						now_q <= in_data.now_time;
						rawin_q <= in_data.raw_levels;
						b_q <= '0;
						state_q <= ST_DEB;
					end
				end
				ST_DEB: begin
					if (bit_raw != raw_q[b_q]) begin
						raw_q[b_q] <= bit_raw;
						rchg_q[b_q] <= now_q;
						state_q <= ST_LONG;
					end else if (raw_q[b_q] != stab_q[b_q] && uge) begin
						stab_q[b_q] <= raw_q[b_q];
						if (raw_q[b_q]) begin
							pstart_q[b_q] <= now_q;
							lfired_q[b_q] <= 1'b0;
							taken_q[b_q] <= 1'b0;
							state_q <= ST_LONG;
						end else if (!lfired_q[b_q]) begin
							state_q <= ST_DBL;
						end else begin
							state_q <= ST_LONG;
						end
					end else begin
						state_q <= ST_LONG;
					end
				end
				ST_DBL: begin
					if (pend_q[b_q] && !uge) begin
						if (out_free) begin
							out_q <= press_word(3'(b_q), bgcd_pkg::PRESS_DOUBLE, taken_q[b_q]);
							ov_d = 1'b1;
							pend_q[b_q] <= 1'b0;
							state_q <= ST_LONG;
						end
					end else begin
						pend_q[b_q] <= 1'b1;
						rel_q[b_q] <= now_q;
						state_q <= ST_LONG;
					end
				end
				ST_LONG: begin
					if (stab_q[b_q] && !lfired_q[b_q] && uge) begin
						if (out_free) begin
							out_q <= press_word(3'(b_q), bgcd_pkg::PRESS_LONG, taken_q[b_q]);
							ov_d = 1'b1;
							lfired_q[b_q] <= 1'b1;
							pend_q[b_q] <= 1'b0;
							state_q <= ST_GAP;
						end
					end else begin
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					if (pend_q[b_q] && uge) begin
						if (out_free) begin
							out_q <= press_word(3'(b_q), bgcd_pkg::PRESS_SHORT, taken_q[b_q]);
							ov_d = 1'b1;
							pend_q[b_q] <= 1'b0;
							c_q <= '0;
							state_q <= ST_SEQW;
						end
					end else if (last_b) begin
						c_q <= '0;
						k_q <= '0;
						fail_q <= 1'b0;
						stat_pass_q <= 1'b0;
						state_q <= ST_CHK;
					end else begin
						b_q <= b_q + 1'b1;
						state_q <= ST_DEB;
					end
				end
				ST_SEQW: begin
					// Normalize progress: wrap when complete, drop when window elapsed.
					if (cuse && !cd[0]) begin
						if (prog >= clen || (prog != 4'd0 && uge)) prog_q[c_q] <= 4'd0;
						state_q <= ST_SEQ;
					end else if (last_c) begin
						if (last_b) begin
							c_q <= '0;
							k_q <= '0;
							fail_q <= 1'b0;
							stat_pass_q <= 1'b0;
							state_q <= ST_CHK;
						end else begin
							b_q <= b_q + 1'b1;
							state_q <= ST_DEB;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_SEQ: begin
					if ({1'b0, dbtn(cd, prog[2:0])} == 4'(b_q)) begin
						if (prog + 4'd1 >= clen) begin
							if (out_free) begin
								out_q <= combo_word(2'(c_q));
								ov_d = 1'b1;
								prog_q[c_q] <= 4'd0;
								if (prog == 4'd0) sstart_q[c_q] <= now_q;
								state_q <= ST_EMIT;
							end
						end else begin
							if (prog == 4'd0) sstart_q[c_q] <= now_q;
							prog_q[c_q] <= prog + 4'd1;
							state_q <= ST_EMIT;
						end
					end else if ({1'b0, dbtn(cd, 3'd0)} == 4'(b_q)) begin
						prog_q[c_q] <= 4'd1;
						sstart_q[c_q] <= now_q;
						state_q <= ST_EMIT;
					end else begin
						prog_q[c_q] <= 4'd0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Step to the next combo after a sequence update.
					if (last_c) begin
						if (last_b) begin
							c_q <= '0;
							k_q <= '0;
							fail_q <= 1'b0;
							stat_pass_q <= 1'b0;
							state_q <= ST_CHK;
						end else begin
							b_q <= b_q + 1'b1;
							state_q <= ST_DEB;
						end
					end else begin
						c_q <= c_q + 1'b1;
						state_q <= ST_SEQW;
					end
				end
				ST_CHK: begin
					// Walk chord members one per cycle, tracking earliest and latest start.
					if (!(cuse && cd[0])) begin
						if (stat_pass_q) held_q[c_q] <= 1'b0;
						k_q <= '0;
						fail_q <= 1'b0;
						if (last_c) begin
							if (stat_pass_q) state_q <= ST_STAT;
							else begin
								stat_pass_q <= 1'b1;
								c_q <= '0;
							end
						end else c_q <= c_q + 1'b1;
					end else if (4'(k_q) < clen && !fail_q) begin
						if (!mok || !stab_q[midx]) fail_q <= 1'b1;
						else if (k_q == '0) begin
							lo_q <= mstart;
							hi_q <= mstart;
						end else begin
							if (mstart - lo_q >= 32'h8000_0000) lo_q <= mstart;
							if (mstart != hi_q && (mstart - hi_q < 32'h8000_0000)) hi_q <= mstart;
						end
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					k_q <= '0;
					if (stat_pass_q) begin
						held_q[c_q] <= !fail_q;
						fail_q <= 1'b0;
						if (last_c) state_q <= ST_STAT;
						else begin
							state_q <= ST_CHK;
							c_q <= c_q + 1'b1;
						end
					end else if (fail_q) begin
						cdone_q[c_q] <= 1'b0;
						fail_q <= 1'b0;
						state_q <= ST_CHK;
						if (last_c) begin
							stat_pass_q <= 1'b1;
							c_q <= '0;
						end else c_q <= c_q + 1'b1;
					end else if (!cdone_q[c_q] && uge) begin
						state_q <= ST_FIRE;
					end else begin
						state_q <= ST_CHK;
						if (last_c) begin
							stat_pass_q <= 1'b1;
							c_q <= '0;
						end else c_q <= c_q + 1'b1;
					end
				end
				ST_FIRE: begin
					if (out_free) begin
						taken_q <= taken_q | fire_mask;
						out_q <= combo_word(2'(c_q));
						ov_d = 1'b1;
						cdone_q[c_q] <= 1'b1;
						state_q <= ST_CHK;
						if (last_c) begin
							stat_pass_q <= 1'b1;
							c_q <= '0;
						end else c_q <= c_q + 1'b1;
					end
				end
				ST_STAT: begin
					if (out_free) begin
						out_q <= status_word(stab8, hold8, 4'(held_q), act);
						ov_d = 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			out_valid_q <= ov_d;
		end
	end

endmodule

@@ tb/button_gesture_combo_detector_unit_chk.sv @@
// ----------------------------------------------------------------------------
// button_gesture_combo_detector_unit_chk
// Watches the poll, result and register channels of the gesture detector,
// predicts every result word from its own copy of the state and compares.
// ----------------------------------------------------------------------------
module button_gesture_combo_detector_unit_chk (
	input  logic                clk,
	input  logic                in_valid,
	input  logic                in_ready,
	input  bgcd_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  bgcd_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [44:0]         cfg_data,
	output int                  fails,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	bgcd_pkg::out_word_t gesture_q[$];

	logic [15:0] deb_ms = bgcd_pkg::DEBOUNCE_RST;
	logic [15:0] long_ms = bgcd_pkg::LONG_RST;
	logic [15:0] gap_ms = bgcd_pkg::DOUBLE_GAP_RST;
	logic [2:0]  ccount = '0;
	logic [44:0] cdef[4] = '{default: '0};

	bit          raw_lv[8] = '{default: 0};
	bit          stab_lv[8] = '{default: 0};
	bit          long_done[8] = '{default: 0};
	bit          wait_second[8] = '{default: 0};
	bit          taken[8] = '{default: 0};
	logic [31:0] raw_t[8] = '{default: '0};
	logic [31:0] press_t[8] = '{default: '0};
	logic [31:0] rel_t[8] = '{default: '0};
	logic [3:0]  seq_pos[4] = '{default: '0};
	logic [31:0] seq_t[4] = '{default: '0};
	bit          chord_hit[4] = '{default: 0};

	function automatic bit aged(logic [31:0] now, logic [31:0] start, logic [31:0] dur);
		logic [31:0] d;
		d = now - start;
		return d >= dur;
	endfunction

	function automatic int combos_used();
		return (ccount > 3'd4) ? 4 : int'(ccount);
	endfunction

	function automatic int steps(logic [44:0] d);
		int n;
		n = int'(d[4:1]);
		return (n > 8) ? 8 : n;
	endfunction

	function automatic int step_btn(logic [44:0] d, int k);
		return int'(d[5 + 3 * k +: 3]);
	endfunction

	function automatic bit chord_down(logic [44:0] d, output logic [31:0] span);
		int n;
		int b;
		logic [31:0] s, lo, hi, t;
		lo = '0;
		hi = '0;
		span = '0;
		n = steps(d);
		for (int k = 0; k < n; k++) begin
			b = step_btn(d, k);
			if (!stab_lv[b])
				return 0;
			s = press_t[b];
			if (k == 0) begin
				lo = s;
				hi = s;
			end else begin
				t = s - lo;
				if (t[31])
					lo = s;
				t = s - hi;
				if (s != hi && !t[31])
					hi = s;
			end
		end
		span = hi - lo;
		return 1;
	endfunction

	task automatic push_word(logic [1:0] kind, int btn, logic [1:0] pk, bit sup, int cid);
		bgcd_pkg::out_word_t w;
		w = '0;
		w.item_kind = kind;
		w.button_id = 3'(btn);
		w.press_kind = pk;
		w.suppressed = sup;
		w.combo_id = 2'(cid);
		gesture_q.push_back(w);
	endtask

	task automatic advance_seq(int b, logic [31:0] now);
		logic [44:0] d;
		int n;
		for (int i = 0; i < combos_used(); i++) begin
			d = cdef[i];
			n = steps(d);
			if (d[0] || n == 0)
				continue;
			if (seq_pos[i] >= n)
				seq_pos[i] = '0;
			if (seq_pos[i] > 0 && aged(now, seq_t[i], {16'd0, d[44:29]}))
				seq_pos[i] = '0;
			if (step_btn(d, int'(seq_pos[i])) == b) begin
				if (seq_pos[i] == 0)
					seq_t[i] = now;
				seq_pos[i]++;
				if (seq_pos[i] >= n) begin
					push_word(bgcd_pkg::KIND_COMBO, 0, bgcd_pkg::PRESS_SHORT, 0, i);
					seq_pos[i] = '0;
				end
			end else if (step_btn(d, 0) == b) begin
				seq_pos[i] = 4'd1;
				seq_t[i] = now;
			end else begin
				seq_pos[i] = '0;
			end
		end
	endtask

	task automatic predict_poll(logic [31:0] now, logic [7:0] raws);
		logic [44:0] d;
		logic [31:0] span;
		bgcd_pkg::out_word_t st;
		int n;
		bit act;
		st = '0;
		act = 0;
		for (int b = 0; b < 8; b++) begin
			if (raws[b] != raw_lv[b]) begin
				raw_lv[b] = raws[b];
				raw_t[b] = now;
			end else if (raw_lv[b] != stab_lv[b] && aged(now, raw_t[b], {16'd0, deb_ms})) begin
				stab_lv[b] = raw_lv[b];
				if (stab_lv[b]) begin
					press_t[b] = now;
					long_done[b] = 0;
					taken[b] = 0;
				end else if (!long_done[b]) begin
					if (wait_second[b] &&
					    !aged(now, rel_t[b], {16'd0, gap_ms} + 32'd1)) begin
						push_word(bgcd_pkg::KIND_PRESS, b, bgcd_pkg::PRESS_DOUBLE, taken[b], 0);
						wait_second[b] = 0;
					end else begin
						wait_second[b] = 1;
						rel_t[b] = now;
					end
				end
			end
			if (stab_lv[b] && !long_done[b] && aged(now, press_t[b], {16'd0, long_ms})) begin
				long_done[b] = 1;
				wait_second[b] = 0;
				push_word(bgcd_pkg::KIND_PRESS, b, bgcd_pkg::PRESS_LONG, taken[b], 0);
			end
			if (wait_second[b] && aged(now, rel_t[b], {16'd0, gap_ms})) begin
				wait_second[b] = 0;
				push_word(bgcd_pkg::KIND_PRESS, b, bgcd_pkg::PRESS_SHORT, taken[b], 0);
				advance_seq(b, now);
			end
		end

		for (int i = 0; i < combos_used(); i++) begin
			d = cdef[i];
			n = steps(d);
			if (!d[0] || n == 0)
				continue;
			if (!chord_down(d, span)) begin
				chord_hit[i] = 0;
				continue;
			end
			if (!chord_hit[i] && span <= {16'd0, d[44:29]}) begin
				for (int k = 0; k < n; k++)
					taken[step_btn(d, k)] = 1;
				push_word(bgcd_pkg::KIND_COMBO, 0, bgcd_pkg::PRESS_SHORT, 0, i);
				chord_hit[i] = 1;
			end
		end

		for (int b = 0; b < 8; b++) begin
			st.stable_levels[b] = stab_lv[b];
			st.hold_active[b] = stab_lv[b] && long_done[b];
			if (raw_lv[b] || stab_lv[b] || wait_second[b])
				act = 1;
		end
		for (int i = 0; i < combos_used(); i++) begin
			d = cdef[i];
			if (d[0] && steps(d) != 0 && chord_down(d, span))
				st.chords_held[i] = 1'b1;
			if (seq_pos[i] > 0 || chord_hit[i])
				act = 1;
		end
		st.item_kind = bgcd_pkg::KIND_STATUS;
		st.activity = act;
		st.last_item = 1'b1;
		gesture_q.push_back(st);
	endtask

	task automatic apply_reg(logic [2:0] idx, logic [44:0] val);
		case (idx)
			bgcd_pkg::REG_DEBOUNCE: begin
				deb_ms = val[15:0];
			end
			bgcd_pkg::REG_LONG: begin
				long_ms = val[15:0];
			end
			bgcd_pkg::REG_DOUBLE_GAP: begin
				gap_ms = val[15:0];
			end
			bgcd_pkg::REG_COMBO_CNT: begin
				ccount = val[2:0];
			end
			default: begin
				cdef[idx - bgcd_pkg::REG_COMBO_A] = val;
			end
		endcase
		// Every register write restarts combo tracking.
		taken = '{default: 0};
		seq_pos = '{default: '0};
		seq_t = '{default: '0};
		chord_hit = '{default: 0};
	endtask

	task automatic report(string what, int got, int want);
		$display("%0t: result word field %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			report(what, got, want);
	endtask

	always @(posedge clk) begin
		bgcd_pkg::out_word_t w;
		if (out_valid && out_ready) begin
			if (gesture_q.size() == 0) begin
				report("unexpected word", int'(out_data.item_kind), -1);
			end else begin
				w = gesture_q.pop_front();
				check_field("item_kind", out_data.item_kind, w.item_kind);
				check_field("button_id", out_data.button_id, w.button_id);
				check_field("press_kind", out_data.press_kind, w.press_kind);
				check_field("suppressed", out_data.suppressed, w.suppressed);
				check_field("combo_id", out_data.combo_id, w.combo_id);
				check_field("stable_levels", out_data.stable_levels, w.stable_levels);
				check_field("hold_active", out_data.hold_active, w.hold_active);
				check_field("chords_held", out_data.chords_held, w.chords_held);
				check_field("activity", out_data.activity, w.activity);
				check_field("last_item", out_data.last_item, w.last_item);
			end
		end
		if (cfg_valid && cfg_ready)
			apply_reg(cfg_index, cfg_data);
		if (in_valid && in_ready)
			predict_poll(in_data.now_time, in_data.raw_levels);
		pending <= gesture_q.size();
	end

endmodule

@@ tb/button_gesture_combo_detector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// button_gesture_combo_detector_unit_tb
// Drives polls and register writes into the gesture detector under random
// stalls on both sides; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module button_gesture_combo_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	bgcd_pkg::in_word_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 0;
	bgcd_pkg::out_word_t out_data;
	logic                cfg_valid = 0;
	logic                cfg_ready;
	logic [2:0]          cfg_index = '0;
	logic [44:0]         cfg_data = '0;
	int                  fails;
	int                  pending;

	bit          calm = 0;
	int          idle_cycles = 0;
	int          polls_sent = 0;
	int          writes_sent = 0;
	logic [7:0]  held_mask = '0;

	button_gesture_combo_detector_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	button_gesture_combo_detector_unit_chk chk (
		.clk(clk),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("button_gesture_combo_detector_unit: mismatch");
			$finish;
		end
	end

	// Result side: a random stall before each word, none while calm.
	initial begin
		int n;
		forever begin
			n = calm ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	function automatic logic [44:0] combo_word(bit chord, int len, logic [23:0] ids, int win);
		return {16'(win), ids, 4'(len), chord};
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [44:0] val);
		int n;
		n = calm ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			cfg_valid <= 0;
			repeat (n) @(posedge clk);
		end
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
		writes_sent++;
	endtask

	task automatic poll(logic [31:0] t, logic [7:0] r);
		int n;
		n = calm ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{now_time: t, raw_levels: r};
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		polls_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random polls: mostly presses of the buttons that the combos use, some
	// chord pairs and triples, glitches shorter than one poll and rare large time jumps.
	task automatic random_polls(int count, int step_max, logic [31:0] base);
		logic [31:0] t;
		logic [7:0] glitch;
		int r;
		t = base;
		for (int k = 0; k < count; k++) begin
			if (k % 25 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (k == count / 2)
				drain();
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2, 3: held_mask ^= 8'(1 << $urandom_range(1, 6));
				4: held_mask ^= 8'h18;
				5: held_mask ^= 8'(1 << $urandom_range(0, 7));
				6: held_mask ^= 8'h07;
				default: ;
			endcase
			glitch = ($urandom_range(0, 9) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
			t += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, step_max);
			poll(t, held_mask ^ glitch);
		end
		calm = 0;
	endtask

	task automatic typical_setup(int count);
		write_reg(bgcd_pkg::REG_DEBOUNCE, 45'd3);
		write_reg(bgcd_pkg::REG_LONG, 45'd60);
		write_reg(bgcd_pkg::REG_DOUBLE_GAP, 45'd20);
		write_reg(bgcd_pkg::REG_COMBO_A, combo_word(0, 2, {18'd0, 3'd2, 3'd1}, 200));
		write_reg(bgcd_pkg::REG_COMBO_B, combo_word(1, 2, {18'd0, 3'd4, 3'd3}, 10));
		write_reg(bgcd_pkg::REG_COMBO_C, combo_word(0, 3, {15'd0, 3'd6, 3'd5, 3'd5}, 300));
		write_reg(bgcd_pkg::REG_COMBO_D, combo_word(1, 3, {15'd0, 3'd2, 3'd1, 3'd0}, 65535));
		write_reg(bgcd_pkg::REG_COMBO_CNT, 45'(count));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (4) @(posedge clk);

		// Reset settings: all buttons, long press, short, double, time wrap.
		poll(32'd0, 8'h00);
		poll(32'd5, 8'hFF);
		poll(32'd30, 8'hFF);
		poll(32'd700, 8'hFF);
		poll(32'd710, 8'h00);
		poll(32'd740, 8'h00);
		poll(32'd2000, 8'h01);
		poll(32'd2030, 8'h01);
		poll(32'd2100, 8'h00);
		poll(32'd2130, 8'h00);
		poll(32'd2500, 8'h00);
		poll(32'd3000, 8'h80);
		poll(32'd3030, 8'h80);
		poll(32'd3050, 8'h00);
		poll(32'd3080, 8'h00);
		poll(32'd3100, 8'h80);
		poll(32'd3130, 8'h80);
		poll(32'd3150, 8'h00);
		poll(32'd3180, 8'h00);
		poll(32'hFFFF_FFF0, 8'h02);
		poll(32'h0000_0010, 8'h02);
		poll(32'h0000_0100, 8'h00);
		poll(32'h0000_0200, 8'h00);
		poll(32'h0000_0500, 8'h00);
		held_mask = '0;
		drain();

		typical_setup(4);
		random_polls(90, 12, 32'h0001_0000);
		drain();

		// Extremes: zero times, count above range, over-long and empty combos.
		write_reg(bgcd_pkg::REG_DEBOUNCE, 45'd0);
		write_reg(bgcd_pkg::REG_LONG, 45'd0);
		write_reg(bgcd_pkg::REG_DOUBLE_GAP, 45'd0);
		write_reg(bgcd_pkg::REG_COMBO_A, combo_word(0, 15, 24'o21212121, 0));
		write_reg(bgcd_pkg::REG_COMBO_B, combo_word(1, 0, 24'o76543210, 65535));
		write_reg(bgcd_pkg::REG_COMBO_C, combo_word(1, 2, {18'd0, 3'd4, 3'd3}, 0));
		write_reg(bgcd_pkg::REG_COMBO_D, combo_word(0, 1, {21'd0, 3'd7}, 65535));
		write_reg(bgcd_pkg::REG_COMBO_CNT, 45'd7);
		random_polls(40, 5, 32'hFFFF_FF00);
		drain();

		write_reg(bgcd_pkg::REG_DEBOUNCE, 45'd65535);
		write_reg(bgcd_pkg::REG_LONG, 45'd65535);
		write_reg(bgcd_pkg::REG_DOUBLE_GAP, 45'd65535);
		write_reg(bgcd_pkg::REG_COMBO_A, 45'({$urandom, $urandom} & 64'h1FFF_FFFF_FFFF));
		write_reg(bgcd_pkg::REG_COMBO_B, 45'({$urandom, $urandom} & 64'h1FFF_FFFF_FFFF));
		write_reg(bgcd_pkg::REG_COMBO_CNT, 45'd2);
		random_polls(40, 40000, $urandom);
		drain();

		typical_setup(3);
		random_polls(36, 12, $urandom);
		drain();

		$display("Covered %0d polls and %0d register writes over five settings,",
			polls_sent, writes_sent);
		$display("from zero to full-scale timing, with random stalls on both sides.");
		if (fails == 0)
			$display("button_gesture_combo_detector_unit: match");
		else
			$display("button_gesture_combo_detector_unit: mismatch");
		$finish;
	end

endmodule
